/* hdl/cpos_pkg.sv */
// Shared constants and result kind codes for the closest point on segment block.
package cpos_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  localparam logic [1:0] KIND_INNER = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

endpackage

/* hdl/closest_point_on_segment_top.sv */
// Top level: front end, chain of COORD_WIDTH division cells, result adder.
// Throughput: one transaction per cycle if not stalled; one item per stage.
// Every stage stalls only when its own slot is full and the next one waits.
// Reset (rst, synchronous) clears all stage valid bits; payload is not reset.
module closest_point_on_segment_top import cpos_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] start_z,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] end_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] near_x,
  output logic signed [COORD_WIDTH-1:0] near_y,
  output logic signed [COORD_WIDTH-1:0] near_z,
  output logic [1:0]                    kind
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W + 2;

  logic                  c_vld  [W+1];
  logic                  c_rdy  [W+1];
  logic [2:0][W-1:0]     c_base [W+1];
  logic [2:0]            c_sgn  [W+1];
  logic [2:0][W-1:0]     c_umag [W+1];
  logic [DW-1:0]         c_num  [W+1];
  logic [DW-1:0]         c_den  [W+1];
  logic [1:0]            c_kind [W+1];
  logic [2:0][DW-1:0]    c_rem  [W+1];
  logic [2:0][W-1:0]     c_quo  [W+1];
  logic [2:0][W-1:0]     near;

  cpos_front #(.COORD_WIDTH(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .p         ({point_z, point_y, point_x}),
    .a         ({start_z, start_y, start_x}),
    .b         ({end_z, end_y, end_x}),
    .out_valid (c_vld[0]),
    .out_ready (c_rdy[0]),
    .base      (c_base[0]),
    .sgn       (c_sgn[0]),
    .umag      (c_umag[0]),
    .num       (c_num[0]),
    .den       (c_den[0]),
    .kind      (c_kind[0])
  );

  assign c_rem[0] = '0;
  assign c_quo[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    cpos_cell #(.COORD_WIDTH(W), .IDX(W - 1 - i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_vld[i]),
      .in_ready  (c_rdy[i]),
      .base_i    (c_base[i]),
      .sgn_i     (c_sgn[i]),
      .umag_i    (c_umag[i]),
      .num_i     (c_num[i]),
      .den_i     (c_den[i]),
      .kind_i    (c_kind[i]),
      .rem_i     (c_rem[i]),
      .quo_i     (c_quo[i]),
      .out_valid (c_vld[i+1]),
      .out_ready (c_rdy[i+1]),
      .base      (c_base[i+1]),
      .sgn       (c_sgn[i+1]),
      .umag      (c_umag[i+1]),
      .num       (c_num[i+1]),
      .den       (c_den[i+1]),
      .kind      (c_kind[i+1]),
      .rem       (c_rem[i+1]),
      .quo       (c_quo[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      near[k] = c_sgn[W][k] ? (c_base[W][k] - c_quo[W][k])
                            : (c_base[W][k] + c_quo[W][k]);
    end
  end

  assign out_valid = c_vld[W];
  assign c_rdy[W]  = out_ready;
  assign near_x    = near[0];
  assign near_y    = near[1];
  assign near_z    = near[2];
  assign kind      = c_kind[W];

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind != KIND_NONE) else $error("invalid result kind");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_INNER) |-> (c_quo[W] == '0))
    else $error("clamped result carries an offset");

endmodule

/* hdl/cpos_front.sv */
// Front end: differences, dot products, endpoint classification.
module cpos_front import cpos_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0][COORD_WIDTH-1:0]         p,
  input  logic [2:0][COORD_WIDTH-1:0]         a,
  input  logic [2:0][COORD_WIDTH-1:0]         b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0][COORD_WIDTH-1:0]         base,
  output logic [2:0]                          sgn,
  output logic [2:0][COORD_WIDTH-1:0]         umag,
  output logic [2*COORD_WIDTH+1:0]            num,
  output logic [2*COORD_WIDTH+1:0]            den,
  output logic [1:0]                          kind
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W + 2;
  localparam int SW = 2 * W + 4;
  localparam int DW = 2 * W + 2;

  logic                            v1;
  logic                            rdy1;
  logic [2:0][W-1:0]               a1;
  logic [2:0][W-1:0]               b1;
  logic [2:0][W:0]                 u1;
  logic [2:0][PW-1:0]              pu1;
  logic [2:0][PW-1:0]              uu1;

  logic signed [W:0]               dq   [3];
  logic signed [W:0]               du   [3];
  logic signed [SW-1:0]            num_s;
  logic signed [SW-1:0]            den_s;
  logic [1:0]                      kind_next;
  logic [W:0]                      uabs [3];

  assign rdy1     = !out_valid || out_ready;
  assign in_ready = !v1 || rdy1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dq[k] = $signed({p[k][W-1], p[k]}) - $signed({a[k][W-1], a[k]});
      du[k] = $signed({b[k][W-1], b[k]}) - $signed({a[k][W-1], a[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
    if (in_ready) begin
      for (int k = 0; k < 3; k++) begin
        a1[k]  <= a[k];
        b1[k]  <= b[k];
        u1[k]  <= du[k];
        pu1[k] <= dq[k] * du[k];
        uu1[k] <= du[k] * du[k];
      end
    end
  end

  always_comb begin
    num_s = '0;
    den_s = '0;
    for (int k = 0; k < 3; k++) begin
      num_s = num_s + SW'($signed(pu1[k]));
      den_s = den_s + SW'($signed(uu1[k]));
      uabs[k] = u1[k][W] ? (~u1[k] + 1'b1) : u1[k];
    end
    if (num_s[SW-1] || num_s == '0) begin
      kind_next = KIND_START;
    end else if (num_s >= den_s) begin
      kind_next = KIND_END;
    end else begin
      kind_next = KIND_INNER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy1) begin
      out_valid <= v1;
    end
    if (rdy1) begin
      kind <= kind_next;
      for (int k = 0; k < 3; k++) begin
        base[k] <= (kind_next == KIND_END) ? b1[k] : a1[k];
        sgn[k]  <= u1[k][W];
        umag[k] <= uabs[k][W-1:0];
      end
      num <= (kind_next == KIND_INNER) ? num_s[DW-1:0] : '0;
      den <= (kind_next == KIND_INNER) ? den_s[DW-1:0] : DW'(1);
    end
  end

endmodule

/* hdl/cpos_cell.sv */
// Division cell: one bit of |u| per axis, radix-2 scaled remainder step.
module cpos_cell import cpos_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int IDX         = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0][COORD_WIDTH-1:0]   base_i,
  input  logic [2:0]                    sgn_i,
  input  logic [2:0][COORD_WIDTH-1:0]   umag_i,
  input  logic [2*COORD_WIDTH+1:0]      num_i,
  input  logic [2*COORD_WIDTH+1:0]      den_i,
  input  logic [1:0]                    kind_i,
  input  logic [2:0][2*COORD_WIDTH+1:0] rem_i,
  input  logic [2:0][COORD_WIDTH-1:0]   quo_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0][COORD_WIDTH-1:0]   base,
  output logic [2:0]                    sgn,
  output logic [2:0][COORD_WIDTH-1:0]   umag,
  output logic [2*COORD_WIDTH+1:0]      num,
  output logic [2*COORD_WIDTH+1:0]      den,
  output logic [1:0]                    kind,
  output logic [2:0][2*COORD_WIDTH+1:0] rem,
  output logic [2:0][COORD_WIDTH-1:0]   quo
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W + 2;
  localparam int RW = 2 * W + 4;

  logic [RW-1:0]          t     [3];
  logic [RW-1:0]          den1;
  logic [RW-1:0]          den2;
  logic [2:0][DW-1:0]     rem_next;
  logic [2:0][W-1:0]      quo_next;

  assign in_ready = !out_valid || out_ready;
  assign den1     = RW'(den_i);
  assign den2     = {1'b0, den_i, 1'b0};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k] = {1'b0, rem_i[k], 1'b0} + (umag_i[k][IDX] ? RW'(num_i) : '0);
      if (t[k] >= den2) begin
        rem_next[k] = DW'(t[k] - den2);
        quo_next[k] = {quo_i[k][W-2:0], 1'b0} + W'(2);
      end else if (t[k] >= den1) begin
        rem_next[k] = DW'(t[k] - den1);
        quo_next[k] = {quo_i[k][W-2:0], 1'b1};
      end else begin
        rem_next[k] = t[k][DW-1:0];
        quo_next[k] = {quo_i[k][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      base <= base_i;
      sgn  <= sgn_i;
      umag <= umag_i;
      num  <= num_i;
      den  <= den_i;
      kind <= kind_i;
      rem  <= rem_next;
      quo  <= quo_next;
    end
  end

endmodule
